@@ src/rgcl_pkg.sv @@
// ----------------------------------------------------------------------------
// rgcl_pkg
// Shared types and constants of the radial gradient colour lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package rgcl_pkg;

	localparam int TABLE_LEN = 1024;
	localparam int IDX_W     = $clog2(TABLE_LEN);

	localparam int RAD_W     = 128;
	localparam int ROOT_W    = RAD_W / 2;
	localparam int SQ_STEPS  = RAD_W / 2;
	localparam int NUM_W     = 96;
	localparam int DEN_W     = 64;
	localparam int Q_W       = 31;

	localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

	localparam int MODE_FOCAL = 2;

	localparam logic [1:0] SPREAD_PAD     = 2'd0;
	localparam logic [1:0] SPREAD_REFLECT = 2'd1;
	localparam logic [1:0] SPREAD_REPEAT  = 2'd2;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_SHADE = 1'b1;

	typedef enum logic [7:0] {
		REG_M_XX   = 8'd0,
		REG_M_YX   = 8'd1,
		REG_M_XY   = 8'd2,
		REG_M_YY   = 8'd3,
		REG_OFF_X  = 8'd4,
		REG_OFF_Y  = 8'd5,
		REG_RADIUS = 8'd6,
		REG_MODE   = 8'd7
	} cfg_reg_t;

	typedef struct packed {
		logic              req_type;
		logic signed [15:0] pixel_x;
		logic signed [15:0] pixel_y;
		logic [9:0]        entry_index;
		logic [31:0]       entry_rgba;
	} in_item_t;

	typedef struct packed {
		logic [31:0]      color_rgba;
		logic [IDX_W-1:0] color_index;
	} out_item_t;

	typedef struct packed {
		logic             shade;
		logic [IDX_W-1:0] entry_index;
		logic [31:0]      entry_rgba;
	} ld_t;

	typedef struct packed {
		ld_t         ld;
		logic        neg_disc;
		logic [31:0] ax;
		logic        gx_neg;
		logic [63:0] s;
	} sq_side_t;

	typedef struct packed {
		ld_t  ld;
		logic neg;
		logic force_zero;
		logic force_max;
	} div_side_t;

endpackage

`default_nettype wire

@@ src/rgcl_sqrt.sv @@
// ----------------------------------------------------------------------------
// rgcl_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rgcl_sqrt (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic [rgcl_pkg::RAD_W-1:0]    radicand,
	input  wire rgcl_pkg::sq_side_t            in_side,
	output logic                               out_valid,
	output logic [rgcl_pkg::ROOT_W-1:0]        root,
	output rgcl_pkg::sq_side_t                 out_side
);

	logic [rgcl_pkg::RAD_W-1:0] op_s   [0:rgcl_pkg::SQ_STEPS];
	logic [rgcl_pkg::RAD_W-1:0] res_s  [0:rgcl_pkg::SQ_STEPS];
	logic                       valid_s[0:rgcl_pkg::SQ_STEPS];
	rgcl_pkg::sq_side_t         side_s [0:rgcl_pkg::SQ_STEPS];

	assign op_s[0]    = radicand;
	assign res_s[0]   = '0;
	assign valid_s[0] = in_valid;
	assign side_s[0]  = in_side;

	for (genvar k = 0; k < rgcl_pkg::SQ_STEPS; k++) begin : g_step
		localparam logic [rgcl_pkg::RAD_W-1:0] ONE =
			{{(rgcl_pkg::RAD_W-1){1'b0}}, 1'b1} << (rgcl_pkg::RAD_W - 2 - 2 * k);
		logic [rgcl_pkg::RAD_W-1:0] trial;

		assign trial = res_s[k] + ONE;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (op_s[k] >= trial) begin
					op_s[k+1]  <= op_s[k] - trial;
					res_s[k+1] <= (res_s[k] >> 1) + ONE;
				end else begin
					op_s[k+1]  <= op_s[k];
					res_s[k+1] <= res_s[k] >> 1;
				end
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = valid_s[rgcl_pkg::SQ_STEPS];
	assign root      = res_s[rgcl_pkg::SQ_STEPS][rgcl_pkg::ROOT_W-1:0];
	assign out_side  = side_s[rgcl_pkg::SQ_STEPS];

endmodule

`default_nettype wire

@@ src/rgcl_div.sv @@
// ----------------------------------------------------------------------------
// rgcl_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rgcl_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_valid,
	input  wire logic [rgcl_pkg::NUM_W-1:0]  num,
	input  wire logic [rgcl_pkg::DEN_W-1:0]  den,
	input  wire rgcl_pkg::div_side_t         in_side,
	output logic                             out_valid,
	output logic [rgcl_pkg::Q_W-1:0]         quot,
	output rgcl_pkg::div_side_t              out_side
);

	logic [rgcl_pkg::NUM_W-1:0] rem_s  [0:rgcl_pkg::Q_W];
	logic [rgcl_pkg::DEN_W-1:0] den_s  [0:rgcl_pkg::Q_W];
	logic [rgcl_pkg::Q_W-1:0]   q_s    [0:rgcl_pkg::Q_W];
	logic                       valid_s[0:rgcl_pkg::Q_W];
	rgcl_pkg::div_side_t        side_s [0:rgcl_pkg::Q_W];

	assign rem_s[0]   = num;
	assign den_s[0]   = den;
	assign q_s[0]     = '0;
	assign valid_s[0] = in_valid;
	assign side_s[0]  = in_side;

	for (genvar k = 0; k < rgcl_pkg::Q_W; k++) begin : g_step
		localparam int B = rgcl_pkg::Q_W - 1 - k;
		logic [rgcl_pkg::NUM_W-1:0] dsh;

		assign dsh = {{(rgcl_pkg::NUM_W-rgcl_pkg::DEN_W){1'b0}}, den_s[k]} << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_s[k] >= dsh) begin
					rem_s[k+1] <= rem_s[k] - dsh;
					q_s[k+1]   <= q_s[k] | ({{(rgcl_pkg::Q_W-1){1'b0}}, 1'b1} << B);
				end else begin
					rem_s[k+1] <= rem_s[k];
					q_s[k+1]   <= q_s[k];
				end
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = valid_s[rgcl_pkg::Q_W];
	assign quot      = q_s[rgcl_pkg::Q_W];
	assign out_side  = side_s[rgcl_pkg::Q_W];

endmodule

`default_nettype wire

@@ src/radial_gradient_color_lookup.sv @@
// ----------------------------------------------------------------------------
// radial_gradient_color_lookup
// Throughput: one transaction per cycle; the whole pipeline holds on stall.
// The depth is set by the 64-stage square root and the 31-stage divider.
// Reset sets register defaults and clears valid bits, not the colour table.
// ----------------------------------------------------------------------------
`default_nettype none

module radial_gradient_color_lookup (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                pix_valid,
	output logic                     pix_stall,
	input  wire rgcl_pkg::in_item_t  pix_data,
	output logic                     col_valid,
	input  wire logic                col_stall,
	output rgcl_pkg::out_item_t      col_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [7:0]          cfg_index,
	input  wire logic [31:0]         cfg_data
);

	localparam logic signed [49:0] SAT_HI = 50'sd2147483647;
	localparam logic signed [49:0] SAT_LO = -50'sd2147483648;

	logic signed [31:0] m_xx_q, m_yx_q, m_xy_q, m_yy_q, off_x_q, off_y_q;
	logic [31:0]        radius_q;
	logic [2:0]         mode_q;
	logic               en;
	logic               focal;

	assign cfg_ready = 1'b1;
	assign en        = !col_valid || !col_stall;
	assign pix_stall = !en;
	assign focal     = mode_q[rgcl_pkg::MODE_FOCAL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_xx_q   <= 32'sd65536;
			m_yx_q   <= '0;
			m_xy_q   <= '0;
			m_yy_q   <= 32'sd65536;
			off_x_q  <= '0;
			off_y_q  <= '0;
			radius_q <= 32'd65536;
			mode_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rgcl_pkg::REG_M_XX:   m_xx_q   <= cfg_data;
				rgcl_pkg::REG_M_YX:   m_yx_q   <= cfg_data;
				rgcl_pkg::REG_M_XY:   m_xy_q   <= cfg_data;
				rgcl_pkg::REG_M_YY:   m_yy_q   <= cfg_data;
				rgcl_pkg::REG_OFF_X:  off_x_q  <= cfg_data;
				rgcl_pkg::REG_OFF_Y:  off_y_q  <= cfg_data;
				rgcl_pkg::REG_RADIUS: radius_q <= cfg_data;
				rgcl_pkg::REG_MODE:   mode_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// valid chain of the stages outside the square root and divider
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;
	logic valid_s9, valid_s10, valid_s11, valid_s12;
	logic sq_valid, dv_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
		end else if (en) begin
			valid_s1  <= pix_valid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s4  <= valid_s3;
			valid_s5  <= valid_s4;
			valid_s6  <= valid_s5;
			valid_s7  <= valid_s6;
			valid_s8  <= valid_s7;
			valid_s9  <= sq_valid;
			valid_s10 <= valid_s9;
			valid_s11 <= dv_valid;
			valid_s12 <= valid_s11;
		end
	end

	// stage 1: matrix products
	logic signed [47:0] pxx_s1, pxy_s1, pyx_s1, pyy_s1;
	rgcl_pkg::ld_t      ld_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			pxx_s1            <= m_xx_q * pix_data.pixel_x;
			pxy_s1            <= m_xy_q * pix_data.pixel_y;
			pyx_s1            <= m_yx_q * pix_data.pixel_x;
			pyy_s1            <= m_yy_q * pix_data.pixel_y;
			ld_s1.shade       <= (pix_data.req_type == rgcl_pkg::REQ_SHADE);
			ld_s1.entry_index <= pix_data.entry_index[rgcl_pkg::IDX_W-1:0];
			ld_s1.entry_rgba  <= pix_data.entry_rgba;
		end
	end

	// stage 2: sum and saturate
	logic signed [49:0] sum_x, sum_y;
	logic signed [31:0] gx_s2, gy_s2;
	rgcl_pkg::ld_t      ld_s2;

	assign sum_x = 50'(pxx_s1) + 50'(pxy_s1) + 50'(off_x_q);
	assign sum_y = 50'(pyx_s1) + 50'(pyy_s1) + 50'(off_y_q);

	always_ff @(posedge clk) begin
		if (en) begin
			gx_s2 <= (sum_x > SAT_HI) ? 32'sh7FFF_FFFF :
			         (sum_x < SAT_LO) ? 32'sh8000_0000 : sum_x[31:0];
			gy_s2 <= (sum_y > SAT_HI) ? 32'sh7FFF_FFFF :
			         (sum_y < SAT_LO) ? 32'sh8000_0000 : sum_y[31:0];
			ld_s2 <= ld_s1;
		end
	end

	// stage 3: magnitudes
	logic signed [31:0] gxe;
	logic [31:0]        ax_s3, ay_s3, r_s3;
	logic               gx_neg_s3;
	rgcl_pkg::ld_t      ld_s3;

	assign gxe = (focal && gx_s2 == 32'sd0) ? 32'sd1 : gx_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s3     <= gxe[31] ? (~gxe + 32'd1) : gxe;
			ay_s3     <= gy_s2[31] ? (~gy_s2 + 32'd1) : gy_s2;
			gx_neg_s3 <= gxe[31];
			r_s3      <= (radius_q == 32'd0) ? 32'd1 : radius_q;
			ld_s3     <= ld_s2;
		end
	end

	// stage 4: squares
	logic [63:0]   ax2_s4, ay2_s4, rr_s4;
	logic [31:0]   ax_s4;
	logic          gx_neg_s4;
	rgcl_pkg::ld_t ld_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ax2_s4    <= ax_s3 * ax_s3;
			ay2_s4    <= ay_s3 * ay_s3;
			rr_s4     <= r_s3 * r_s3;
			ax_s4     <= ax_s3;
			gx_neg_s4 <= gx_neg_s3;
			ld_s4     <= ld_s3;
		end
	end

	// stage 5: squared distance
	logic [63:0]   s_s5, ay2_s5, rr_s5;
	logic [31:0]   ax_s5;
	logic          gx_neg_s5;
	rgcl_pkg::ld_t ld_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			s_s5      <= ax2_s4 + ay2_s4;
			ay2_s5    <= ay2_s4;
			rr_s5     <= rr_s4;
			ax_s5     <= ax_s4;
			gx_neg_s5 <= gx_neg_s4;
			ld_s5     <= ld_s4;
		end
	end

	// stage 6: partial products of s * r^2
	logic [63:0]   p0_s6, p1_s6, p2_s6, p3_s6, s_s6, ay2_s6;
	logic [31:0]   ax_s6;
	logic          gx_neg_s6;
	rgcl_pkg::ld_t ld_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s6     <= s_s5[31:0] * rr_s5[31:0];
			p1_s6     <= s_s5[31:0] * rr_s5[63:32];
			p2_s6     <= s_s5[63:32] * rr_s5[31:0];
			p3_s6     <= s_s5[63:32] * rr_s5[63:32];
			s_s6      <= s_s5;
			ay2_s6    <= ay2_s5;
			ax_s6     <= ax_s5;
			gx_neg_s6 <= gx_neg_s5;
			ld_s6     <= ld_s5;
		end
	end

	// stage 7: combine partial products
	logic [127:0]  t1_s7;
	logic [63:0]   s_s7, ay2_s7;
	logic [31:0]   ax_s7;
	logic          gx_neg_s7;
	rgcl_pkg::ld_t ld_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			t1_s7     <= {64'd0, p0_s6} + {32'd0, p1_s6, 32'd0} + {32'd0, p2_s6, 32'd0}
			           + {p3_s6, 64'd0};
			s_s7      <= s_s6;
			ay2_s7    <= ay2_s6;
			ax_s7     <= ax_s6;
			gx_neg_s7 <= gx_neg_s6;
			ld_s7     <= ld_s6;
		end
	end

	// stage 8: radicand, the discriminant (focal) or squared distance (centred)
	logic [127:0]       t2;
	logic [127:0]       rad_s8;
	rgcl_pkg::sq_side_t sqs_s8;

	assign t2 = {32'd0, ay2_s7, 32'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s8          <= focal ? (t1_s7 - t2) : {64'd0, s_s7};
			sqs_s8.ld       <= ld_s7;
			sqs_s8.neg_disc <= (t1_s7 < t2);
			sqs_s8.ax       <= ax_s7;
			sqs_s8.gx_neg   <= gx_neg_s7;
			sqs_s8.s        <= s_s7;
		end
	end

	logic [rgcl_pkg::ROOT_W-1:0] sq_root;
	rgcl_pkg::sq_side_t          sq_side;

	rgcl_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s8),
		.radicand (rad_s8),
		.in_side  (sqs_s8),
		.out_valid(sq_valid),
		.root     (sq_root),
		.out_side (sq_side)
	);

	// stage 9: numerator and denominator
	logic [63:0]                sh;
	logic [rgcl_pkg::NUM_W-1:0] num_s9;
	logic [rgcl_pkg::DEN_W-1:0] den_s9;
	rgcl_pkg::div_side_t        ds_s9;

	assign sh = {16'd0, sq_side.ax, 16'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			ds_s9.ld        <= sq_side.ld;
			ds_s9.force_max <= 1'b0;
			if (focal) begin
				num_s9 <= {{(rgcl_pkg::NUM_W-64){1'b0}}, sq_side.s} << rgcl_pkg::IDX_W;
				ds_s9.force_zero <= sq_side.neg_disc;
				if (!sq_side.gx_neg) begin
					den_s9    <= sq_root + sh;
					ds_s9.neg <= 1'b0;
				end else if (sq_root >= sh) begin
					den_s9    <= sq_root - sh;
					ds_s9.neg <= 1'b0;
				end else begin
					den_s9    <= sh - sq_root;
					ds_s9.neg <= 1'b1;
				end
			end else begin
				num_s9 <= {{(rgcl_pkg::NUM_W-32){1'b0}}, sq_root[31:0]} << rgcl_pkg::IDX_W;
				den_s9 <= {32'd0, ((radius_q == 32'd0) ? 32'd1 : radius_q)};
				ds_s9.force_zero <= 1'b0;
				ds_s9.neg        <= 1'b0;
			end
		end
	end

	// stage 10: saturation test
	logic [rgcl_pkg::NUM_W-1:0] num_s10;
	logic [rgcl_pkg::DEN_W-1:0] den_s10;
	rgcl_pkg::div_side_t        ds_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s10           <= num_s9;
			den_s10           <= den_s9;
			ds_s10.ld         <= ds_s9.ld;
			ds_s10.neg        <= ds_s9.neg;
			ds_s10.force_zero <= ds_s9.force_zero;
			ds_s10.force_max  <= num_s9 >= ({{(rgcl_pkg::NUM_W-rgcl_pkg::DEN_W){1'b0}},
			                                 den_s9} << rgcl_pkg::Q_W);
		end
	end

	logic [rgcl_pkg::Q_W-1:0] dv_quot;
	rgcl_pkg::div_side_t      dv_side;

	rgcl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s10),
		.num      (num_s10),
		.den      (den_s10),
		.in_side  (ds_s10),
		.out_valid(dv_valid),
		.quot     (dv_quot),
		.out_side (dv_side)
	);

	// stage 11: position and spread
	logic [31:0]              mag, pos;
	logic [rgcl_pkg::IDX_W:0] refl;
	logic [rgcl_pkg::IDX_W-1:0] idx;
	logic [rgcl_pkg::IDX_W-1:0] idx_s11;
	rgcl_pkg::ld_t            ld_s11;

	always_comb begin
		mag  = dv_side.force_zero ? 32'd0 :
		       dv_side.force_max  ? rgcl_pkg::POS_MAX : {1'b0, dv_quot};
		pos  = dv_side.neg ? (~mag + 32'd1) : mag;
		refl = pos[rgcl_pkg::IDX_W:0];
		unique case (mode_q[1:0])
			rgcl_pkg::SPREAD_REFLECT:
				idx = refl[rgcl_pkg::IDX_W] ? ~refl[rgcl_pkg::IDX_W-1:0]
				                            : refl[rgcl_pkg::IDX_W-1:0];
			rgcl_pkg::SPREAD_REPEAT:
				idx = pos[rgcl_pkg::IDX_W-1:0];
			default: begin
				if (pos[31])
					idx = '0;
				else if (pos > 32'(rgcl_pkg::TABLE_LEN - 1))
					idx = '1;
				else
					idx = pos[rgcl_pkg::IDX_W-1:0];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s11 <= idx;
			ld_s11  <= dv_side.ld;
		end
	end

	// stage 12: colour table
	logic [31:0] table_mem [0:rgcl_pkg::TABLE_LEN-1];
	logic [31:0] rgba_s12;
	logic [rgcl_pkg::IDX_W-1:0] idx_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			if (valid_s11 && !ld_s11.shade)
				table_mem[ld_s11.entry_index] <= ld_s11.entry_rgba;
			rgba_s12 <= table_mem[idx_s11];
			idx_s12  <= idx_s11;
		end
	end

	logic shade_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			shade_s12 <= 1'b0;
		else if (en)
			shade_s12 <= valid_s11 && ld_s11.shade;
	end

	assign col_valid            = valid_s12 && shade_s12;
	assign col_data.color_rgba  = rgba_s12;
	assign col_data.color_index = idx_s12;

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(valid_s1) && $stable(valid_s9) && $stable(valid_s11))
		else $error("pipeline advanced while stalled");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(en && pix_valid) |=> valid_s1)
		else $error("accepted transaction dropped at entry");

	a_centered_den: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s9 && !focal) |-> (den_s9 != '0))
		else $error("zero divisor in centred mode");

endmodule

`default_nettype wire

@@ bench/radial_gradient_color_lookup_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_gradient_color_lookup_tb
// Fills the colour table, then runs short directed sequences for every
// spread rule, centred and focal modes and their corner cases, followed by
// randomised pixel and table-load traffic under several register settings
// and stall patterns. Colours are predicted in the bench and checked in order.
// ----------------------------------------------------------------------------

module radial_gradient_color_lookup_tb;

	localparam int WATCHDOG_LIMIT = 6000;
	localparam int DRAIN_CYCLES   = 130;

	class colour_scoreboard;
		logic [31:0]           lut [rgcl_pkg::TABLE_LEN];
		logic [31:0]           regs [8];
		rgcl_pkg::out_item_t   pending [$];
		int                    errors;

		function new();
			errors = 0;
			regs[rgcl_pkg::REG_M_XX] = 32'd65536;
			regs[rgcl_pkg::REG_M_YX] = '0;
			regs[rgcl_pkg::REG_M_XY] = '0;
			regs[rgcl_pkg::REG_M_YY] = 32'd65536;
			regs[rgcl_pkg::REG_OFF_X] = '0;
			regs[rgcl_pkg::REG_OFF_Y] = '0;
			regs[rgcl_pkg::REG_RADIUS] = 32'd65536;
			regs[rgcl_pkg::REG_MODE] = '0;
		endfunction

		function void write_reg(logic [7:0] idx, logic [31:0] val);
			if (idx <= rgcl_pkg::REG_MODE)
				regs[idx] = (idx == rgcl_pkg::REG_MODE) ? {29'd0, val[2:0]} : val;
		endfunction

		static function logic [63:0] root(logic [127:0] v);
			logic [63:0] r;
			logic [63:0] t;
			r = '0;
			for (int b = 63; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if ({64'd0, t} * {64'd0, t} <= v)
					r = t;
			end
			return r;
		endfunction

		static function longint sat32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function rgcl_pkg::out_item_t shade(rgcl_pkg::in_item_t it);
			longint gx, gy, pos;
			logic [63:0] ax, ay, s, r, sq, sh, den;
			logic [127:0] t1, t2, q;
			logic neg;
			logic [31:0] p, i;
			rgcl_pkg::out_item_t res;
			gx = sat32(longint'($signed(regs[rgcl_pkg::REG_M_XX])) * it.pixel_x +
				longint'($signed(regs[rgcl_pkg::REG_M_XY])) * it.pixel_y +
				longint'($signed(regs[rgcl_pkg::REG_OFF_X])));
			gy = sat32(longint'($signed(regs[rgcl_pkg::REG_M_YX])) * it.pixel_x +
				longint'($signed(regs[rgcl_pkg::REG_M_YY])) * it.pixel_y +
				longint'($signed(regs[rgcl_pkg::REG_OFF_Y])));
			r = (regs[rgcl_pkg::REG_RADIUS] == 0) ? 64'd1 : {32'd0, regs[rgcl_pkg::REG_RADIUS]};
			if (regs[rgcl_pkg::REG_MODE][rgcl_pkg::MODE_FOCAL]) begin
				if (gx == 0) gx = 1;
				ax = (gx < 0) ? -gx : gx;
				ay = (gy < 0) ? -gy : gy;
				s = ax * ax + ay * ay;
				t1 = {64'd0, s} * {64'd0, r} * {64'd0, r};
				t2 = {64'd0, ay * ay} << 32;
				if (t1 < t2) begin
					pos = 0;
				end else begin
					sq = root(t1 - t2);
					sh = ax << 16;
					neg = 1'b0;
					if (gx > 0) den = sq + sh;
					else if (sq >= sh) den = sq - sh;
					else begin
						den = sh - sq;
						neg = 1'b1;
					end
					if (den == 0) begin
						pos = longint'(rgcl_pkg::POS_MAX);
					end else begin
						q = ({64'd0, s} * 128'(rgcl_pkg::TABLE_LEN)) / {64'd0, den};
						if (q > 128'(rgcl_pkg::POS_MAX)) q = 128'(rgcl_pkg::POS_MAX);
						pos = neg ? -longint'(q[31:0]) : longint'(q[31:0]);
					end
				end
			end else begin
				ax = (gx < 0) ? -gx : gx;
				ay = (gy < 0) ? -gy : gy;
				s = ax * ax + ay * ay;
				q = {64'd0, root({64'd0, s})} * 128'(rgcl_pkg::TABLE_LEN) / {64'd0, r};
				if (q > 128'(rgcl_pkg::POS_MAX)) q = 128'(rgcl_pkg::POS_MAX);
				pos = longint'(q[31:0]);
			end
			p = pos[31:0];
			case (regs[rgcl_pkg::REG_MODE][1:0])
				rgcl_pkg::SPREAD_REFLECT: begin
					i = p & 32'(2 * rgcl_pkg::TABLE_LEN - 1);
					if (i >= 32'(rgcl_pkg::TABLE_LEN))
						i = 32'(2 * rgcl_pkg::TABLE_LEN - 1) - i;
				end
				rgcl_pkg::SPREAD_REPEAT: i = p & 32'(rgcl_pkg::TABLE_LEN - 1);
				default: begin
					if (pos < 0) i = '0;
					else if (pos > rgcl_pkg::TABLE_LEN - 1) i = 32'(rgcl_pkg::TABLE_LEN - 1);
					else i = p;
				end
			endcase
			res.color_index = i[rgcl_pkg::IDX_W-1:0];
			res.color_rgba = lut[i[rgcl_pkg::IDX_W-1:0]];
			return res;
		endfunction

		function void note_input(rgcl_pkg::in_item_t it);
			if (it.req_type == rgcl_pkg::REQ_LOAD)
				lut[it.entry_index] = it.entry_rgba;
			else
				pending.push_back(shade(it));
		endfunction

		function void check_colour(rgcl_pkg::out_item_t got);
			rgcl_pkg::out_item_t want;
			if (pending.size() == 0) begin
				$error("unexpected colour transaction %h", got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.color_rgba !== want.color_rgba) begin
				$error("color_rgba expected %h actual %h", want.color_rgba, got.color_rgba);
				errors++;
			end
			if (got.color_index !== want.color_index) begin
				$error("color_index expected %0d actual %0d",
					want.color_index, got.color_index);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic pix_valid;
	logic pix_stall;
	rgcl_pkg::in_item_t pix_data;
	logic col_valid;
	logic col_stall;
	rgcl_pkg::out_item_t col_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [7:0] cfg_index;
	logic [31:0] cfg_data;

	colour_scoreboard sb;
	int send_gap_pct;
	int recv_stall_pct;
	int quiet_cycles;

	radial_gradient_color_lookup dut (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .pix_data(pix_data),
		.col_valid(col_valid), .col_stall(col_stall), .col_data(col_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		col_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (col_valid && !col_stall)
			sb.check_colour(col_data);
		if ((col_valid && !col_stall) || (pix_valid && !pix_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("radial_gradient_color_lookup_tb failed");
			$finish;
		end
	end

	task automatic send_item(rgcl_pkg::in_item_t it);
		while ($urandom_range(99) < send_gap_pct) begin
			@(negedge clk);
			pix_valid <= 1'b0;
		end
		@(negedge clk);
		pix_valid <= 1'b1;
		pix_data <= it;
		do @(posedge clk); while (pix_stall);
		sb.note_input(it);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [31:0] val);
		@(negedge clk);
		pix_valid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(logic [31:0] mxx, logic [31:0] myx, logic [31:0] mxy,
			logic [31:0] myy, logic [31:0] ox, logic [31:0] oy, logic [31:0] rad,
			logic [2:0] md);
		write_reg(rgcl_pkg::REG_M_XX, mxx);
		write_reg(rgcl_pkg::REG_M_YX, myx);
		write_reg(rgcl_pkg::REG_M_XY, mxy);
		write_reg(rgcl_pkg::REG_M_YY, myy);
		write_reg(rgcl_pkg::REG_OFF_X, ox);
		write_reg(rgcl_pkg::REG_OFF_Y, oy);
		write_reg(rgcl_pkg::REG_RADIUS, rad);
		write_reg(rgcl_pkg::REG_MODE, {29'd0, md});
	endtask

	task automatic drain();
		@(negedge clk);
		pix_valid <= 1'b0;
		while (sb.pending.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic shade_at(int x, int y);
		rgcl_pkg::in_item_t it;
		it.req_type = rgcl_pkg::REQ_SHADE;
		it.pixel_x = x[15:0];
		it.pixel_y = y[15:0];
		it.entry_index = 10'($urandom);
		it.entry_rgba = $urandom;
		send_item(it);
	endtask

	function automatic logic [31:0] rand_term();
		if ($urandom_range(9) == 0) return $urandom;
		return (int'($urandom_range(4095)) - 2048) <<< $urandom_range(8);
	endfunction

	initial begin
		rgcl_pkg::in_item_t it;
		logic [2:0] md;
		logic [31:0] rad;
		sb = new();
		arst_n = 1'b0;
		pix_valid = 1'b0;
		pix_data = '0;
		col_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet_cycles = 0;
		send_gap_pct = 7;
		recv_stall_pct = 82;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int k = 0; k < rgcl_pkg::TABLE_LEN; k++) begin
			it = '0;
			it.req_type = rgcl_pkg::REQ_LOAD;
			it.entry_index = 10'(k);
			it.entry_rgba = $urandom;
			it.pixel_x = 16'($urandom);
			it.pixel_y = 16'($urandom);
			send_item(it);
		end
		drain();

		set_regs(32'd65536, 0, 0, 32'd65536, 0, 0, 32'h0400_0000, 3'd0);
		shade_at(0, 0);
		shade_at(3, 4);
		shade_at(-32768, -32768);
		shade_at(32767, 32767);
		shade_at(-32768, 32767);
		drain();
		write_reg(rgcl_pkg::REG_MODE, 32'd1);
		shade_at(1500, 0);
		shade_at(2047, 0);
		drain();
		write_reg(rgcl_pkg::REG_MODE, 32'd2);
		shade_at(1500, 0);
		drain();
		write_reg(rgcl_pkg::REG_MODE, 32'd3);
		shade_at(1500, 0);
		drain();
		set_regs(32'd65536, 0, 0, 32'd65536, 0, 0, 32'd65536, 3'd4);
		shade_at(0, 0);
		shade_at(-1, 0);
		shade_at(2, 1);
		drain();
		set_regs(32'd65536, 0, 0, 32'd65536, 0, 0, 32'd32768, 3'd5);
		shade_at(0, 5);
		shade_at(-1, 0);
		shade_at(-3, 1);
		drain();
		write_reg(rgcl_pkg::REG_MODE, 32'd6);
		shade_at(-1, 0);
		shade_at(-2, 1);
		drain();
		write_reg(8'(rgcl_pkg::REG_MODE) + 8'd1, 32'hFFFF_FFFF);
		set_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 3'd7);
		shade_at(32767, -32768);
		shade_at(-32768, 32767);
		shade_at(0, 0);
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			case (ph / 3)
				0: begin send_gap_pct = 7; recv_stall_pct = 82; end
				1: begin send_gap_pct = 82; recv_stall_pct = 7; end
				default: begin send_gap_pct = 0; recv_stall_pct = 0; end
			endcase
			md = (ph == 8) ? 3'd1 : 3'($urandom_range(7));
			if (md[rgcl_pkg::MODE_FOCAL]) rad = $urandom_range(32'h4000, 32'h10_0000);
			else rad = $urandom_range(32'h1_0000, 32'h400_0000);
			if (ph == 8) rad = 32'd1;
			set_regs(rand_term(), rand_term(), rand_term(), rand_term(),
				(int'($urandom_range(32'h20_0000)) - 32'sh10_0000),
				(int'($urandom_range(32'h20_0000)) - 32'sh10_0000), rad, md);
			for (int n = 0; n < 18; n++) begin
				it.req_type = ($urandom_range(9) != 0) ? rgcl_pkg::REQ_SHADE
				                                       : rgcl_pkg::REQ_LOAD;
				if ($urandom_range(9) < 7) begin
					it.pixel_x = 16'(int'($urandom_range(600)) - 300);
					it.pixel_y = 16'(int'($urandom_range(600)) - 300);
				end else begin
					it.pixel_x = 16'($urandom);
					it.pixel_y = 16'($urandom);
				end
				it.entry_index = 10'($urandom);
				it.entry_rgba = $urandom;
				send_item(it);
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("radial_gradient_color_lookup_tb passed");
		else
			$display("radial_gradient_color_lookup_tb failed");
		$finish;
	end

endmodule

@@ sim.f @@
src/rgcl_pkg.sv
src/rgcl_sqrt.sv
src/rgcl_div.sv
src/radial_gradient_color_lookup.sv
bench/radial_gradient_color_lookup_tb.sv
